// File: rtl/core/bpool_pkg.sv
// Package for the buffer pool frame table: shared constants, request and
// status codes, controller states and the controller/datapath command types.
// No dependencies.
`default_nettype none
package bpool_pkg;
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 24;
    localparam int PIN_BITS_DEF  = 8;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int FCNT_W   = 5;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [FUNC_W-1:0] FN_PIN   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_UNPIN = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DIRTY = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FORCE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FLUSH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PINNED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RANK, S_DONE
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;     // capture request, clear scan state
        logic scan;     // examine one frame
        logic decide;   // apply the operation once the scan is complete
        logic rank;     // age one frame for make-newest
        logic finish;   // present result
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic scan_last;
        logic rank_last;
        logic need_rank;
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/core/bpool_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bpool_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: rtl/core/bpool_ctrl.sv
// Controller for the buffer pool: sequences scan, decide, rank and result.
// Depends on bpool_pkg.
`default_nettype none
module bpool_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_out_free,
    input  wire bpool_pkg::t_stat i_stat,
    output bpool_pkg::t_cmd     o_cmd,
    output logic                o_busy
);
    bpool_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bpool_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bpool_pkg::S_IDLE:   if (i_start) n_state = bpool_pkg::S_SCAN;
            bpool_pkg::S_SCAN:   if (i_stat.scan_last) n_state = bpool_pkg::S_DECIDE;
            bpool_pkg::S_DECIDE: n_state = i_stat.need_rank ? bpool_pkg::S_RANK
                                                            : bpool_pkg::S_DONE;
            bpool_pkg::S_RANK:   if (i_stat.rank_last) n_state = bpool_pkg::S_DONE;
            bpool_pkg::S_DONE:   if (i_out_free) n_state = bpool_pkg::S_IDLE;
            default:             n_state = bpool_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            bpool_pkg::S_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start;
            end
            bpool_pkg::S_SCAN:   o_cmd.scan = 1'b1;
            bpool_pkg::S_DECIDE: o_cmd.decide = 1'b1;
            bpool_pkg::S_RANK:   o_cmd.rank = 1'b1;
            bpool_pkg::S_DONE:   o_cmd.finish = i_out_free;
            default:             o_busy = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/bpool_dp.sv
// Datapath for the buffer pool: frame flags, scan registers, tag RAM and
// result assembly. Depends on bpool_pkg and bpool_ram.
`default_nettype none
module bpool_dp #(
    parameter int FRAMES    = bpool_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = bpool_pkg::PAGE_BITS_DEF,
    parameter int PIN_BITS  = bpool_pkg::PIN_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bpool_pkg::t_cmd               i_cmd,
    input  wire logic [bpool_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [PAGE_BITS-1:0]          i_page,
    input  wire logic [bpool_pkg::CFG_W-1:0]   i_limit_raw,
    input  wire logic                          i_policy,
    output bpool_pkg::t_stat                   o_stat,
    output logic [bpool_pkg::STATUS_W-1:0]     o_status,
    output logic [bpool_pkg::FIDX_W-1:0]       o_fidx,
    output logic                               o_hit,
    output logic                               o_nread,
    output logic                               o_nwb,
    output logic [PAGE_BITS-1:0]               o_wbpage,
    output logic [bpool_pkg::FCNT_W-1:0]       o_flushed,
    output logic [bpool_pkg::CNT_W-1:0]        o_reads,
    output logic [bpool_pkg::CNT_W-1:0]        o_writes
);
    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    logic [FRAMES-1:0]   r_valid, r_dirty;
    logic [PIN_BITS-1:0] r_pin  [FRAMES];
    logic [IW-1:0]       r_rank [FRAMES];
    logic [CW-1:0]       r_filled;
    logic [bpool_pkg::CNT_W-1:0] r_reads, r_writes;

    logic [bpool_pkg::FUNC_W-1:0] r_func;
    logic [PAGE_BITS-1:0]         r_page;
    logic [CW-1:0]                r_idx;   // scan/rank counter, one frame per cycle
    logic                         r_found;
    logic [IW-1:0]                r_fhit;
    logic                         r_vok;
    logic [IW-1:0]                r_vic, r_best;
    logic [CW-1:0]                r_flushed;
    logic [IW-1:0]                r_target;
    logic [CW-1:0]                r_old;   // rank bound: FRAMES for a fresh frame

    // Tag RAM: read at the scan index, written at decide time when a missing page is placed.
    // Reads are registered, so the scan compares the previous index's tag.
    logic              ram_we;
    logic [IW-1:0]     ram_addr;
    logic [PAGE_BITS-1:0] ram_rdata;
    logic              r_cmp_v;
    logic [IW-1:0]     r_cmp_i;

    bpool_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES)) u_tag (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(r_page), .o_rdata(ram_rdata)
    );

    logic [CW-1:0] limit;
    logic [IW-1:0] idx_i;
    logic          in_scan, scan_more;
    logic          is_fill;
    logic [IW-1:0] fill_f;

    always_comb begin
        if (i_limit_raw == '0) limit = CW'(1);
        else if (32'(i_limit_raw) > FRAMES) limit = CW'(FRAMES);
        else limit = CW'(i_limit_raw);
        idx_i     = r_idx[IW-1:0];
        scan_more = r_idx < r_filled;
        in_scan   = i_cmd.scan && scan_more;
        is_fill   = r_filled < limit;
        fill_f    = r_filled[IW-1:0];
    end

    logic dec_pin_miss, dec_pin_hit, dec_evict_ok;
    logic [IW-1:0] newf;
    always_comb begin
        dec_pin_hit  = (r_func == bpool_pkg::FN_PIN) && r_found;
        dec_pin_miss = (r_func == bpool_pkg::FN_PIN) && !r_found;
        dec_evict_ok = dec_pin_miss && (is_fill || r_vok);
        newf         = is_fill ? fill_f : r_vic;
        ram_we       = i_cmd.decide && dec_evict_ok;
        if (ram_we) ram_addr = newf;
        else if (i_cmd.decide) ram_addr = r_fhit;
        else if (i_cmd.scan && !scan_more) ram_addr = r_vic;
        else ram_addr = idx_i;
    end

    always_comb begin
        o_stat.scan_last = !scan_more && !r_cmp_v;
        o_stat.rank_last = !(CW'(r_idx + 1'b1) < r_filled);
        o_stat.need_rank = (dec_pin_hit && i_policy) || dec_evict_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            r_filled  <= '0;
            r_reads   <= '0;
            r_writes  <= '0;
            r_cmp_v   <= 1'b0;
            for (int k = 0; k < FRAMES; k++) begin
                r_pin[k]  <= '0;
                r_rank[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_func    <= i_func;
                r_page    <= i_page;
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_fhit    <= '0;
                r_vok     <= 1'b0;
                r_vic     <= '0;
                r_best    <= '0;
                r_flushed <= '0;
                r_cmp_v   <= 1'b0;
                o_status  <= bpool_pkg::ST_OK;
                o_fidx    <= '0;
                o_hit     <= 1'b0;
                o_nread   <= 1'b0;
                o_nwb     <= 1'b0;
                o_wbpage  <= '0;
                o_flushed <= '0;
            end
            if (i_cmd.scan) begin
                r_cmp_v <= in_scan;
                r_cmp_i <= idx_i;
                if (in_scan) begin
                    r_idx <= r_idx + 1'b1;
                    if (r_valid[idx_i] && r_pin[idx_i] == '0 &&
                        (!r_vok || r_rank[idx_i] > r_best)) begin
                        r_vok  <= 1'b1;
                        r_vic  <= idx_i;
                        r_best <= r_rank[idx_i];
                    end
                    if (r_func == bpool_pkg::FN_FLUSH && r_valid[idx_i] &&
                        r_dirty[idx_i] && r_pin[idx_i] == '0) begin
                        r_dirty[idx_i] <= 1'b0;
                        r_flushed      <= r_flushed + 1'b1;
                        r_writes       <= r_writes + 1'b1;
                    end
                end
                if (r_cmp_v && r_func <= bpool_pkg::FN_FORCE && !r_found &&
                    r_valid[r_cmp_i] && ram_rdata == r_page) begin
                    r_found <= 1'b1;
                    r_fhit  <= r_cmp_i;
                end
            end
            if (i_cmd.decide) begin
                r_idx <= '0;
                o_flushed <= bpool_pkg::FCNT_W'(r_flushed);
                if (dec_pin_hit) begin
                    o_fidx <= bpool_pkg::FIDX_W'(r_fhit);
                    o_hit  <= 1'b1;
                    if (r_pin[r_fhit] < PIN_MAX) r_pin[r_fhit] <= r_pin[r_fhit] + 1'b1;
                    r_target <= r_fhit;
                    r_old    <= CW'(r_rank[r_fhit]);
                end else if (dec_pin_miss) begin
                    if (!dec_evict_ok) begin
                        o_status <= bpool_pkg::ST_PINNED;
                    end else begin
                        if (!is_fill && r_dirty[r_vic]) begin
                            o_nwb    <= 1'b1;
                            o_wbpage <= ram_rdata;   // victim tag read at the end of the scan
                            r_writes <= r_writes + 1'b1;
                        end
                        if (is_fill) r_filled <= r_filled + 1'b1;
                        o_fidx   <= bpool_pkg::FIDX_W'(newf);
                        o_nread  <= 1'b1;
                        r_reads  <= r_reads + 1'b1;
                        r_valid[newf] <= 1'b1;
                        r_dirty[newf] <= 1'b0;
                        r_pin[newf]   <= PIN_BITS'(1);
                        r_target <= newf;
                        r_old    <= r_valid[newf] ? CW'(r_rank[newf]) : CW'(FRAMES);
                    end
                end else if (r_func <= bpool_pkg::FN_FORCE) begin
                    if (!r_found) begin
                        o_status <= bpool_pkg::ST_MISSING;
                    end else begin
                        o_fidx <= bpool_pkg::FIDX_W'(r_fhit);
                        case (r_func)
                            bpool_pkg::FN_UNPIN:
                                if (r_pin[r_fhit] != '0) r_pin[r_fhit] <= r_pin[r_fhit] - 1'b1;
                            bpool_pkg::FN_DIRTY: r_dirty[r_fhit] <= 1'b1;
                            bpool_pkg::FN_FORCE: begin
                                o_nwb    <= 1'b1;
                                o_wbpage <= r_page;
                                r_dirty[r_fhit] <= 1'b0;
                                r_writes <= r_writes + 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            if (i_cmd.rank) begin
                r_idx <= r_idx + 1'b1;
                if (idx_i != r_target && r_valid[idx_i] && CW'(r_rank[idx_i]) < r_old)
                    r_rank[idx_i] <= r_rank[idx_i] + 1'b1;
                if (o_stat.rank_last) r_rank[r_target] <= '0;
            end
        end
    end

    // The victim tag must be read before decide: it is fetched on the last
    // scan cycles so that ram_rdata holds it at decide time.
    assign o_reads  = r_reads;
    assign o_writes = r_writes;
endmodule
`default_nettype wire

// File: rtl/core/buffer_pool_fifo_lru_replacement.sv
// Buffer pool frame table with FIFO or LRU replacement.
// The scan examines one frame per cycle, followed by a rank pass over the filled frames
// when ranks are updated (LRU hit or new page). A new item is accepted only once the
// previous result has been taken into the output register.
// Synchronous active-low reset empties the pool, zeroes totals, sets 16 frames and FIFO order.
// Depends on bpool_pkg, bpool_ctrl, bpool_dp, bpool_ram.
`default_nettype none
module buffer_pool_fifo_lru_replacement #(
    parameter int FRAMES    = bpool_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = bpool_pkg::PAGE_BITS_DEF,
    parameter int PIN_BITS  = bpool_pkg::PIN_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [4:0]   i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [2:0] func, [2+PAGE_BITS:3] page_number, zero pad to bytes
    input  wire logic [((3+PAGE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], frame_index[5:2], hit[6], need_read[7], need_writeback[8],
    // writeback_page, flushed_count(5), read_total(32), write_total(32), pad
    output logic [((78+PAGE_BITS+7)/8)*8-1:0] m_axis_tdata
);
    localparam int OW = ((78 + PAGE_BITS + 7) / 8) * 8;
    logic [bpool_pkg::CFG_W-1:0] r_limit;
    logic r_policy, r_ovalid;
    logic [OW-1:0] r_odata;
    bpool_pkg::t_cmd cmd;
    bpool_pkg::t_stat stat;
    logic busy;
    logic [1:0] st; logic [3:0] fi; logic hit, nr, nw;
    logic [PAGE_BITS-1:0] wbp; logic [4:0] fl; logic [31:0] rd, wr;

    // The result is held in its own register so the next item can be processed
    // while it waits for the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= 5'd16;
            r_policy <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == bpool_pkg::REG_FRAMES) r_limit <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == bpool_pkg::REG_POLICY) r_policy <= i_cfg_data[0];
            if (cmd.finish) begin
                r_ovalid <= 1'b1;
                r_odata  <= OW'({wr, rd, fl, wbp, nw, nr, hit, fi, st});
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = !busy;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    bpool_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_axis_tvalid),
        .i_out_free(!r_ovalid || m_axis_tready), .i_stat(stat),
        .o_cmd(cmd), .o_busy(busy)
    );

    bpool_dp #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS), .PIN_BITS(PIN_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_func(s_axis_tdata[2:0]), .i_page(s_axis_tdata[3 +: PAGE_BITS]),
        .i_limit_raw(r_limit), .i_policy(r_policy), .o_stat(stat),
        .o_status(st), .o_fidx(fi), .o_hit(hit), .o_nread(nr), .o_nwb(nw),
        .o_wbpage(wbp), .o_flushed(fl), .o_reads(rd), .o_writes(wr)
    );
endmodule
`default_nettype wire
